FILE: src/stpq_pkg.sv
// Shared types and codes for the stereo PCM ring queue.
package stpq_pkg;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_PUSH  = 2'd0;
  localparam kind_t KIND_POP   = 2'd1;
  localparam kind_t KIND_HIST  = 2'd2;
  localparam kind_t KIND_CLEAR = 2'd3;

  // Where the result word of an item takes its frame from.
  typedef logic [1:0] src_t;

  localparam src_t SRC_NONE  = 2'd0;
  localparam src_t SRC_QUEUE = 2'd1;
  localparam src_t SRC_HIST  = 2'd2;

  localparam int MIN_CAPACITY = 256;

  // One stereo frame: left in the low half, right in the high half.
  typedef struct packed {
    logic signed [15:0] right;
    logic signed [15:0] left;
  } frame_t;

  typedef struct packed {
    logic [31:0] dropped;
    logic [31:0] underflow;
    logic [31:0] epoch;
  } stats_t;

endpackage

FILE: src/stpq_frame_ram.sv
// Single-port-write, single-port-read frame memory with registered read data.
module stpq_frame_ram #(
  parameter int DEPTH = 4096
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  stpq_pkg::frame_t       wdata,
  input  logic                   re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output stpq_pkg::frame_t       rdata
);
  import stpq_pkg::*;

  frame_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/stpq_ctrl.sv
// Pointer, fill and counter logic; issues the frame memory accesses.
module stpq_ctrl #(
  parameter int MAX_FRAMES     = 4096,
  parameter int HISTORY_FRAMES = 4096
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  accept,
  input  stpq_pkg::kind_t                       kind,
  input  stpq_pkg::frame_t                      frame,
  input  logic [11:0]                           age,
  input  logic                                  cfg_we,
  input  logic [12:0]                           cfg_data,
  output logic                                  q_we,
  output logic [$clog2(MAX_FRAMES)-1:0]         q_waddr,
  output logic                                  q_re,
  output logic [$clog2(MAX_FRAMES)-1:0]         q_raddr,
  output logic                                  h_we,
  output logic [$clog2(HISTORY_FRAMES)-1:0]     h_waddr,
  output logic                                  h_re,
  output logic [$clog2(HISTORY_FRAMES)-1:0]     h_raddr,
  output stpq_pkg::frame_t                      wdata,
  output stpq_pkg::src_t                        src,
  output logic [$clog2(MAX_FRAMES+1)-1:0]       fill,
  output stpq_pkg::stats_t                      stats
);
  import stpq_pkg::*;

  localparam int QAW = $clog2(MAX_FRAMES);
  localparam int QFW = $clog2(MAX_FRAMES + 1);
  localparam int HAW = $clog2(HISTORY_FRAMES);
  localparam int HFW = $clog2(HISTORY_FRAMES + 1);
  localparam int HCW = (HFW > 12) ? HFW : 12;

  logic [QFW-1:0] cap;
  logic [QAW-1:0] q_head;
  logic [QFW-1:0] q_fill;
  logic [HAW-1:0] h_head;
  logic [HFW-1:0] h_fill;
  stats_t         cnt;

  logic           q_full;
  logic           q_empty;
  logic [QAW-1:0] q_head_inc;
  logic [QFW:0]   q_sum;
  logic [QAW-1:0] q_tail;
  logic           h_full;
  logic [HAW-1:0] h_head_inc;
  logic [HFW:0]   h_sum;
  logic [HAW-1:0] h_tail;
  logic [HCW-1:0] age_ext;
  logic [HCW-1:0] h_fill_ext;
  logic           h_hit;
  logic [HFW-1:0] h_back;
  logic [HFW:0]   h_rsum;
  logic [31:0]    cap_req;
  logic [QFW-1:0] cap_next;

  // Queue pointers: all modulo the live capacity.
  assign q_full  = (q_fill >= cap);
  assign q_empty = (q_fill == '0);
  assign q_head_inc = ((QFW'(q_head) + QFW'(1)) == cap) ? '0 : q_head + 1'b1;
  assign q_sum  = (QFW+1)'(q_head) + (QFW+1)'(q_fill);
  assign q_tail = (q_sum >= (QFW+1)'(cap)) ? QAW'(q_sum - (QFW+1)'(cap)) : QAW'(q_sum);

  // History ring: modulo the fixed ring size.
  assign h_full = (h_fill >= HFW'(HISTORY_FRAMES));
  assign h_head_inc = (h_head == HAW'(HISTORY_FRAMES - 1)) ? '0 : h_head + 1'b1;
  assign h_sum  = (HFW+1)'(h_head) + (HFW+1)'(h_fill);
  assign h_tail = (h_sum >= (HFW+1)'(HISTORY_FRAMES)) ?
                  HAW'(h_sum - (HFW+1)'(HISTORY_FRAMES)) : HAW'(h_sum);

  assign age_ext    = HCW'(age);
  assign h_fill_ext = HCW'(h_fill);
  assign h_hit      = (age_ext < h_fill_ext);
  assign h_back     = HFW'(h_fill_ext - HCW'(1) - age_ext);
  assign h_rsum     = (HFW+1)'(h_head) + (HFW+1)'(h_back);

  // Clamp the written capacity.
  assign cap_req = 32'(cfg_data);
  always_comb begin
    if (cap_req < 32'(MIN_CAPACITY)) begin
      cap_next = QFW'(MIN_CAPACITY);
    end else if (cap_req > 32'(MAX_FRAMES)) begin
      cap_next = QFW'(MAX_FRAMES);
    end else begin
      cap_next = QFW'(cap_req);
    end
  end

  // Memory accesses of the accepted word.
  assign wdata   = frame;
  assign q_we    = accept && (kind == KIND_PUSH);
  assign q_waddr = q_full ? q_head : q_tail;
  assign q_re    = accept && (kind == KIND_POP) && !q_empty;
  assign q_raddr = q_head;
  assign h_we    = accept && (kind == KIND_PUSH);
  assign h_waddr = h_full ? h_head : h_tail;
  assign h_re    = accept && (kind == KIND_HIST) && h_hit;
  assign h_raddr = (h_rsum >= (HFW+1)'(HISTORY_FRAMES)) ?
                   HAW'(h_rsum - (HFW+1)'(HISTORY_FRAMES)) : HAW'(h_rsum);

  always_comb begin
    unique case (kind)
      KIND_POP:  src = q_empty ? SRC_NONE : SRC_QUEUE;
      KIND_HIST: src = h_hit ? SRC_HIST : SRC_NONE;
      default:   src = SRC_NONE;
    endcase
  end

  assign fill  = q_fill;
  assign stats = cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap    <= QFW'(MAX_FRAMES);
      q_head <= '0;
      q_fill <= '0;
      h_head <= '0;
      h_fill <= '0;
      cnt    <= '0;
    end else if (cfg_we) begin
      cap    <= cap_next;
      q_head <= '0;
      q_fill <= '0;
    end else if (accept) begin
      unique case (kind)
        KIND_PUSH: begin
          if (q_full) begin
            // drop the oldest frame
            q_head      <= q_head_inc;
            q_fill      <= cap;
            cnt.dropped <= cnt.dropped + 32'd1;
          end else begin
            q_fill <= q_fill + 1'b1;
          end
          if (h_full) begin
            h_head <= h_head_inc;
          end else begin
            h_fill <= h_fill + 1'b1;
          end
        end
        KIND_POP: begin
          if (q_empty) begin
            cnt.underflow <= cnt.underflow + 32'd1;
          end else begin
            q_head <= q_head_inc;
            q_fill <= q_fill - 1'b1;
          end
        end
        KIND_HIST: begin
        end
        KIND_CLEAR: begin
          q_head        <= '0;
          q_fill        <= '0;
          h_head        <= '0;
          h_fill        <= '0;
          cnt.underflow <= '0;
          cnt.epoch     <= cnt.epoch + 32'd1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: src/stereo_pcm_ring_queue.sv
// Top level of the stereo PCM frame queue with history tap.
//
// Stereo 16-bit frame queue plus a history ring. Each input word is a push,
// a pop, a history read by age (0 is the newest frame) or a clear, and
// yields exactly one result word, in order. A push into a full queue drops
// the oldest frame and bumps dropped_count; a pop from an empty queue bumps
// underflow_count and returns out_valid = 0. Every push also lands in the
// history ring of HISTORY_FRAMES frames. Clear empties both rings, zeroes
// underflow_count and bumps epoch_count. The queue capacity register is
// clamped to 256..MAX_FRAMES and writing it empties the queue; write it only
// while no result is outstanding. The control logic update and the
// registered frame memory read both happen at the accepting edge; the
// result word then moves from the pending stage into the result register
// once that register is free, and one word per cycle is sustained as long
// as results are taken. Frame memories need no clearing pass after reset:
// only entries written by a push are ever read.
module stereo_pcm_ring_queue #(
  parameter int MAX_FRAMES     = 4096,
  parameter int HISTORY_FRAMES = 4096
) (
  input  logic                clk,
  input  logic                rst,
  // input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  stpq_pkg::kind_t     kind,
  input  logic signed [15:0]  left_sample,
  input  logic signed [15:0]  right_sample,
  input  logic [11:0]         history_age,
  // capacity register
  input  logic                capacity_frames_we,
  input  logic [12:0]         capacity_frames,
  // result channel
  output logic                result_valid,
  input  logic                result_ready,
  output logic signed [15:0]  out_left,
  output logic signed [15:0]  out_right,
  output logic                out_valid,
  output logic [12:0]         frames_available,
  output logic [31:0]         dropped_count,
  output logic [31:0]         underflow_count,
  output logic [31:0]         epoch_count
);
  import stpq_pkg::*;

  localparam int QAW = $clog2(MAX_FRAMES);
  localparam int QFW = $clog2(MAX_FRAMES + 1);
  localparam int HAW = $clog2(HISTORY_FRAMES);

  logic           accept;
  logic           out_free;
  logic           p_adv;
  logic           p_valid;
  src_t           p_src;

  logic           q_we;
  logic [QAW-1:0] q_waddr;
  logic           q_re;
  logic [QAW-1:0] q_raddr;
  frame_t         q_rdata;
  logic           h_we;
  logic [HAW-1:0] h_waddr;
  logic           h_re;
  logic [HAW-1:0] h_raddr;
  frame_t         h_rdata;
  frame_t         wdata;
  frame_t         in_frame;
  src_t           src;
  logic [QFW-1:0] fill;
  stats_t         stats;

  assign in_frame.left  = left_sample;
  assign in_frame.right = right_sample;

  // The pending stage holds the word whose memory read is in flight; it
  // doubles as the skid stage while the result register is stalled.
  assign out_free = !result_valid || result_ready;
  assign p_adv    = p_valid && out_free;
  assign in_ready = !p_valid || out_free;
  assign accept   = in_valid && in_ready;

  stpq_ctrl #(
    .MAX_FRAMES     (MAX_FRAMES),
    .HISTORY_FRAMES (HISTORY_FRAMES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .kind     (kind),
    .frame    (in_frame),
    .age      (history_age),
    .cfg_we   (capacity_frames_we),
    .cfg_data (capacity_frames),
    .q_we     (q_we),
    .q_waddr  (q_waddr),
    .q_re     (q_re),
    .q_raddr  (q_raddr),
    .h_we     (h_we),
    .h_waddr  (h_waddr),
    .h_re     (h_re),
    .h_raddr  (h_raddr),
    .wdata    (wdata),
    .src      (src),
    .fill     (fill),
    .stats    (stats)
  );

  stpq_frame_ram #(
    .DEPTH (MAX_FRAMES)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (wdata),
    .re    (q_re),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  stpq_frame_ram #(
    .DEPTH (HISTORY_FRAMES)
  ) u_history_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (wdata),
    .re    (h_re),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  // Control of the pending stage and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        p_valid <= 1'b1;
      end else if (p_adv) begin
        p_valid <= 1'b0;
      end
      if (p_adv) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Remember where the pending word takes its frame from.
  always_ff @(posedge clk) begin
    if (accept) begin
      p_src <= src;
    end
  end

  // Load the result word. The counters and fill already reflect the pending
  // word: any word accepted on this same edge updates them only after it.
  always_ff @(posedge clk) begin
    if (p_adv) begin
      case (p_src)
        SRC_QUEUE: begin
          out_left  <= q_rdata.left;
          out_right <= q_rdata.right;
          out_valid <= 1'b1;
        end
        SRC_HIST: begin
          out_left  <= h_rdata.left;
          out_right <= h_rdata.right;
          out_valid <= 1'b1;
        end
        default: begin
          out_left  <= '0;
          out_right <= '0;
          out_valid <= 1'b0;
        end
      endcase
      frames_available <= 13'(fill);
      dropped_count    <= stats.dropped;
      underflow_count  <= stats.underflow;
      epoch_count      <= stats.epoch;
    end
  end

endmodule
